[src/kts_pkg.sv]
`timescale 1ns / 1ps
package kts_pkg;
  localparam int KeysPerTrack = 64;
  localparam int Tracks       = 3;
  localparam int SlotW        = $clog2(KeysPerTrack);
  localparam int AddrW        = $clog2(Tracks * KeysPerTrack);
  localparam int CountW       = $clog2(KeysPerTrack + 1);
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 7;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;
  localparam logic [1:0] TRK_POS = 2'd0;
  localparam logic [1:0] TRK_ROT = 2'd1;
  localparam logic [1:0] TRK_SCL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POS_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCL_COUNT = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  track;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_w;
    logic [31:0] sample_time;
  } kts_in_t;

  typedef struct packed {
    logic [1:0]  out_track;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic        last;
  } kts_out_t;

  // divider request / reply
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } kts_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } kts_div_rsp_t;
endpackage

[src/kts_if.sv]
`timescale 1ns / 1ps
interface kts_in_if import kts_pkg::*; ();
  logic    valid;
  logic    ready;
  kts_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kts_out_if import kts_pkg::*; ();
  logic     valid;
  logic     ready;
  kts_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/kts_ram.sv]
`timescale 1ns / 1ps
module kts_ram #(
  parameter int Width = 32,
  parameter int Depth = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/kts_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle, 16-bit quotient
module kts_div import kts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  kts_div_req_t req,
  output kts_div_rsp_t rsp
);
  logic [47:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], num_r[47]};
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[46:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

[src/kts_blend.sv]
`timescale 1ns / 1ps
// one component blend: a + floor((b - a) * f / 2^16), product and a registered
module kts_blend (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic        [15:0] f,
  output logic signed [31:0] y
);
  logic signed [32:0] diff;
  logic signed [49:0] prod_r;
  logic signed [31:0] a_r;
  logic signed [49:0] sh;

  assign diff = 33'(b) - 33'(a);

  always_ff @(posedge clk) begin
    prod_r <= 50'(diff) * $signed({34'd0, f});
    a_r    <= a;
  end

  // arithmetic shift floors, matching the rounding toward minus infinity
  assign sh = prod_r >>> 16;
  assign y  = a_r + sh[31:0];
endmodule

[src/keyframe_track_sampler.sv]
`timescale 1ns / 1ps
// keyframe_track_sampler: three keyframe tracks in block ram, sampled by time
// key write: accepted while idle, no result, next item taken right after
// sample: three results, per track a scan of up to 64 keys, each key a SCAN and a TEST state
//   (one ram read port), then the bit-serial divider and the blend;
//   no new item is taken until the last result is loaded into the output register
// reset: synchronous active-low rst_n clears control state and key counts;
//   key storage is undefined until written
module keyframe_track_sampler import kts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  kts_in_if.sink              in_ch,
  kts_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // address issued, data next cycle
  localparam logic [3:0] S_TEST  = 4'd2;  // compare key time with sample time
  localparam logic [3:0] S_RDA   = 4'd3;  // read first bracketing key
  localparam logic [3:0] S_RDB   = 4'd4;  // latch first bracketing key; second was latched in S_TEST
  localparam logic [3:0] S_GOTB  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_BLND  = 4'd7;
  localparam logic [3:0] S_BLND2 = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_NEXT  = 4'd10;
  localparam logic [3:0] S_RDS   = 4'd11; // single key read
  localparam logic [3:0] S_GOTS  = 4'd12;

  logic [3:0]        st_r, st_nxt;
  logic [CountW-1:0] cnt_r [Tracks];
  logic [1:0]        trk_r, trk_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;       // scan position
  logic [31:0]       s_r, s_nxt;           // sample time
  logic [31:0]       t1_r, t1_nxt;
  logic [31:0]       t2_r, t2_nxt;
  logic [63:0]       xy_a_r, xy_a_nxt, zw_a_r, zw_a_nxt;
  logic [63:0]       xy_b_r, xy_b_nxt, zw_b_r, zw_b_nxt;
  logic [15:0]       f_r, f_nxt;
  logic              ov_r, ov_nxt;         // output holds an item
  kts_out_t          od_r, od_nxt;
  kts_out_t          res_r, res_nxt;       // result being built for the current track

  // ram ports
  logic              ram_we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [31:0]       rd_time;
  logic [63:0]       rd_xy, rd_zw;
  kts_div_req_t      dreq;
  kts_div_rsp_t      drsp;
  logic signed [31:0] bl_y [4];
  logic [CountW-1:0] n_cur;
  logic [AddrW-1:0]  base;
  logic              acc;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign ram_we = acc && (in_ch.data.opcode == OP_WRITE) &&
                  (in_ch.data.track != 2'd3);
  assign waddr = AddrW'(in_ch.data.track) * AddrW'(KeysPerTrack) +
                 AddrW'(in_ch.data.key_index);

  kts_ram #(.Width(32), .Depth(Tracks * KeysPerTrack)) u_time (
    .clk, .we(ram_we), .waddr, .wdata(in_ch.data.key_time), .raddr, .rdata(rd_time));
  kts_ram #(.Width(64), .Depth(Tracks * KeysPerTrack)) u_xy (
    .clk, .we(ram_we), .waddr,
    .wdata({in_ch.data.comp_y, in_ch.data.comp_x}), .raddr, .rdata(rd_xy));
  kts_ram #(.Width(64), .Depth(Tracks * KeysPerTrack)) u_zw (
    .clk, .we(ram_we), .waddr,
    .wdata({in_ch.data.comp_w, in_ch.data.comp_z}), .raddr, .rdata(rd_zw));

  kts_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  kts_blend u_bx (.clk, .a(xy_a_r[31:0]),  .b(xy_b_r[31:0]),  .f(f_r), .y(bl_y[0]));
  kts_blend u_by (.clk, .a(xy_a_r[63:32]), .b(xy_b_r[63:32]), .f(f_r), .y(bl_y[1]));
  kts_blend u_bz (.clk, .a(zw_a_r[31:0]),  .b(zw_b_r[31:0]),  .f(f_r), .y(bl_y[2]));
  kts_blend u_bw (.clk, .a(zw_a_r[63:32]), .b(zw_b_r[63:32]), .f(f_r), .y(bl_y[3]));

  // counts above the track depth saturate
  always_comb begin
    n_cur = cnt_r[trk_r];
    if (cnt_r[trk_r] > CountW'(KeysPerTrack)) begin
      n_cur = CountW'(KeysPerTrack);
    end
  end
  assign base = AddrW'(trk_r) * AddrW'(KeysPerTrack);

  always_comb begin
    st_nxt   = st_r;
    trk_nxt  = trk_r;
    idx_nxt  = idx_r;
    s_nxt    = s_r;
    t1_nxt   = t1_r;
    t2_nxt   = t2_r;
    xy_a_nxt = xy_a_r;
    zw_a_nxt = zw_a_r;
    xy_b_nxt = xy_b_r;
    zw_b_nxt = zw_b_r;
    f_nxt    = f_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    res_nxt  = res_r;
    raddr    = base + AddrW'(idx_r);
    dreq.start = 1'b0;
    dreq.num   = {s_r - t1_r, 16'd0};
    dreq.den   = t2_r - t1_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (acc && in_ch.data.opcode == OP_SAMPLE) begin
          s_nxt   = in_ch.data.sample_time;
          trk_nxt = TRK_POS;
          st_nxt  = S_NEXT;
        end
      end
      S_NEXT: begin
        // start of one track
        idx_nxt = '0;
        res_nxt.out_track = trk_r;
        res_nxt.last = (trk_r == TRK_SCL);
        if (n_cur == '0) begin
          res_nxt.out_x = (trk_r == TRK_SCL) ? OneQ16 : '0;
          res_nxt.out_y = (trk_r == TRK_SCL) ? OneQ16 : '0;
          res_nxt.out_z = (trk_r == TRK_SCL) ? OneQ16 : '0;
          res_nxt.out_w = (trk_r == TRK_ROT) ? OneQ16 : '0;
          st_nxt = S_OUT;
        end else if (n_cur == CountW'(1)) begin
          st_nxt = S_RDS;
        end else begin
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        st_nxt = S_TEST;
      end
      S_TEST: begin
        if (rd_time > s_r) begin
          if (idx_r == '0) begin
            st_nxt = S_RDS;
          end else begin
            t2_nxt  = rd_time;
            xy_b_nxt = rd_xy;
            zw_b_nxt = rd_zw;
            idx_nxt = idx_r - CountW'(1);
            st_nxt  = S_RDA;
          end
        end else if (idx_r + CountW'(1) >= n_cur) begin
          st_nxt = S_RDS;
        end else begin
          idx_nxt = idx_r + CountW'(1);
          st_nxt  = S_SCAN;
        end
      end
      S_RDS: begin
        // idx_r points at the key to show (0 when single key)
        if (n_cur == CountW'(1)) begin
          idx_nxt = '0;
          raddr   = base;
        end
        st_nxt = S_GOTS;
      end
      S_GOTS: begin
        res_nxt.out_x = rd_xy[31:0];
        res_nxt.out_y = rd_xy[63:32];
        res_nxt.out_z = rd_zw[31:0];
        res_nxt.out_w = (trk_r == TRK_ROT) ? rd_zw[63:32] : '0;
        st_nxt = S_OUT;
      end
      S_RDA: begin
        st_nxt = S_RDB;
      end
      S_RDB: begin
        t1_nxt   = rd_time;
        xy_a_nxt = rd_xy;
        zw_a_nxt = rd_zw;
        st_nxt   = S_GOTB;
      end
      S_GOTB: begin
        dreq.start = 1'b1;
        st_nxt = S_DIV;
      end
      S_DIV: begin
        if (drsp.done) begin
          f_nxt  = drsp.quo;
          st_nxt = S_BLND;
        end
      end
      S_BLND: begin
        st_nxt = S_BLND2;
      end
      S_BLND2: begin
        res_nxt.out_x = bl_y[0];
        res_nxt.out_y = bl_y[1];
        res_nxt.out_z = bl_y[2];
        res_nxt.out_w = (trk_r == TRK_ROT) ? bl_y[3] : '0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to be free
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          if (trk_r == TRK_SCL) begin
            st_nxt = S_IDLE;
          end else begin
            trk_nxt = trk_r + 2'd1;
            st_nxt  = S_NEXT;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      trk_r <= TRK_POS;
      for (int i = 0; i < Tracks; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      trk_r <= trk_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_POS_COUNT: cnt_r[0] <= cfg_data;
          CFG_ROT_COUNT: cnt_r[1] <= cfg_data;
          CFG_SCL_COUNT: cnt_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
    idx_r  <= idx_nxt;
    s_r    <= s_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    xy_a_r <= xy_a_nxt;
    zw_a_r <= zw_a_nxt;
    xy_b_r <= xy_b_nxt;
    zw_b_r <= zw_b_nxt;
    f_r    <= f_nxt;
    od_r   <= od_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
endmodule

[src/kts_checker.sv]
`timescale 1ns / 1ps
module kts_checker import kts_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input kts_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.out_track == TRK_SCL)))
    else $error("last flag mismatch");
  a_trk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_track != 2'd3)
    else $error("bad track");
  a_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_track != TRK_ROT |-> out_data.out_w == '0)
    else $error("w not zero on vector track");
endmodule

bind keyframe_track_sampler kts_checker u_chk (
  .clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
